FILE: hw/rtl/normalized_legendre_recursion_core_assert.svh
// assertion macros used by the legendre recursion back end
`ifndef NORMALIZED_LEGENDRE_RECURSION_CORE_ASSERT_SVH
`define NORMALIZED_LEGENDRE_RECURSION_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define NLR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define NLR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/nlr_pkg.sv
// types, constants and coefficient tables for the legendre recursion
package nlr_pkg;

  localparam int MAX_DEGREE      = 9;
  localparam int VALUE_FRAC_BITS = 20;
  localparam int NUM_COEF        = (MAX_DEGREE + 1) * (MAX_DEGREE + 2) / 2;
  localparam int IDX_W           = $clog2(NUM_COEF);
  localparam int COEF_W          = 29;
  localparam int VAL_W           = 24;
  localparam int T_W             = 16;
  localparam int DEG_W           = 4;
  localparam int ROOT_W          = 24;

  localparam logic [63:0] SEED_Q40 = 64'd310166503690;
  localparam logic signed [VAL_W-1:0] SEED_VAL =
    VAL_W'((SEED_Q40 + (64'd1 << (39 - VALUE_FRAC_BITS))) >> (40 - VALUE_FRAC_BITS));

  typedef logic [COEF_W-1:0] coef_arr_t [NUM_COEF];

  typedef struct packed {
    logic signed [T_W-1:0] t;
    logic [ROOT_W-1:0]     root;
    logic [DEG_W-1:0]      lim;
  } task_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] xin);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] b;
    x   = xin;
    res = 64'd0;
    b   = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= res + b) begin
        x   = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // restoring long division, used only while the tables are built
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // a coefficients; the two seed slots of each degree hold sqrt(2k+1) and c_k
  function automatic coef_arr_t build_a();
    coef_arr_t   tab;
    logic [63:0] num;
    logic [63:0] den;
    int          idx;
    for (int i = 0; i < NUM_COEF; i++) tab[i] = '0;
    for (int k = 1; k <= MAX_DEGREE; k++) begin
      for (int l = 0; l <= k; l++) begin
        idx = ((k * (k + 1)) >> 1) + l;
        if (l == k) begin
          num = 64'(2 * k + 1);
          den = 64'(2 * k);
        end else if (l == k - 1) begin
          num = 64'(2 * k + 1);
          den = 64'd1;
        end else begin
          num = 64'((2 * k + 1) * (2 * k - 1));
          den = 64'((k + l) * (k - l));
        end
        tab[idx] = COEF_W'(isqrt64(udiv64(num << 52, den)));
      end
    end
    return tab;
  endfunction

  function automatic coef_arr_t build_b();
    coef_arr_t   tab;
    logic [63:0] num;
    logic [63:0] den;
    int          idx;
    for (int i = 0; i < NUM_COEF; i++) tab[i] = '0;
    for (int k = 2; k <= MAX_DEGREE; k++) begin
      for (int l = 0; l + 1 < k; l++) begin
        idx = ((k * (k + 1)) >> 1) + l;
        num = 64'((2 * k + 1) * (k + l - 1) * (k - l - 1));
        den = 64'((k + l) * (k - l) * (2 * k - 3));
        tab[idx] = COEF_W'(isqrt64(udiv64(num << 52, den)));
      end
    end
    return tab;
  endfunction

  localparam coef_arr_t COEF_A = build_a();
  localparam coef_arr_t COEF_B = build_b();

endpackage

FILE: hw/rtl/normalized_legendre_recursion_core.sv
// top level of the fully normalized associated legendre recursion core
// Each transfer on the in_ side carries one argument t (signed Q2.14, clamped
// to [-1,1]) and produces the fully normalized associated Legendre values
// P_k^l(t), without the Condon-Shortley phase, for k = 0..degree_limit and
// l = 0..k in degree-major order, as signed Q3.20 on the out_ side; out_last
// marks the final value of a sample. degree_limit (cfg_wdata, reset 9) is
// clamped to 9; the user must see that it is written only while the core is idle,
// and the core does not enforce this. Per sample the front end captures the
// argument, runs 24 steps of the bit-serial square root for sqrt(1-t^2)
// and hands off; the back end takes the sample from the queue, writes
// P_0^0 and then each value with its single shared multiplier (coefficient
// times t, or times the root on the diagonal, rounding, two products, then
// round/saturate); a full sample holds 55 values at degree limit 9. The
// two ends are coupled by a two-entry queue, so the next argument's square
// root overlaps the current recursion; results wait in a two-entry output queue.
module normalized_legendre_recursion_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic signed [nlr_pkg::T_W-1:0]     in_sample,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic signed [nlr_pkg::VAL_W-1:0]   out_value,
  output logic [nlr_pkg::DEG_W-1:0]          out_degree,
  output logic [nlr_pkg::DEG_W-1:0]          out_order,
  output logic                               out_last,
  input  logic                               cfg_we,
  input  logic [nlr_pkg::DEG_W-1:0]          cfg_wdata
);
  import nlr_pkg::*;

  // degree limit register
  logic [DEG_W-1:0] deg_lim_r;

  // front to queue
  task_t tsk_in;
  logic  tsk_push;
  logic  tsk_full;

  // queue to back
  task_t tsk_out;
  logic  tsk_pop;
  logic  tsk_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_lim_r <= DEG_W'(MAX_DEGREE);
    end else if (cfg_we) begin
      deg_lim_r <= cfg_wdata;
    end
  end

  // clamp and square root
  nlr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_sample (in_sample),
    .deg_lim   (deg_lim_r),
    .tsk       (tsk_in),
    .tsk_push  (tsk_push),
    .tsk_full  (tsk_full)
  );

  // decoupling queue
  nlr_task_q u_task_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (tsk_push),
    .din   (tsk_in),
    .full  (tsk_full),
    .pop   (tsk_pop),
    .empty (tsk_empty),
    .dout  (tsk_out)
  );

  // recursion and result transfer
  nlr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .tsk        (tsk_out),
    .tsk_empty  (tsk_empty),
    .tsk_pop    (tsk_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_value  (out_value),
    .out_degree (out_degree),
    .out_order  (out_order),
    .out_last   (out_last)
  );

endmodule

FILE: hw/rtl/nlr_front.sv
// front end: clamps the argument and finds sqrt(1-t^2) bit by bit
module nlr_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic signed [nlr_pkg::T_W-1:0]   in_sample,
  input  logic [nlr_pkg::DEG_W-1:0]        deg_lim,
  output nlr_pkg::task_t                   tsk,
  output logic                             tsk_push,
  input  logic                             tsk_full
);
  import nlr_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_SQRT, F_PUSH} fstate_t;

  fstate_t               state_r;
  logic signed [T_W-1:0] t_r;
  logic [DEG_W-1:0]      lim_r;
  logic [47:0]           rem_r;
  logic [47:0]           res_r;
  logic [47:0]           bit_r;

  logic signed [T_W-1:0] t_sat;
  logic signed [31:0]    t_sq;
  logic [28:0]           rad;
  logic [47:0]           trial;

  always_comb begin
    if (in_sample > 16'sd16384) t_sat = 16'sd16384;
    else if (in_sample < -16'sd16384) t_sat = -16'sd16384;
    else t_sat = in_sample;
    t_sq  = t_sat * t_sat;
    rad   = (29'd1 << 28) - t_sq[28:0];
    trial = res_r + bit_r;
  end

  assign in_full  = (state_r != F_IDLE);
  assign tsk_push = (state_r == F_PUSH) && !tsk_full;
  assign tsk      = '{t: t_r, root: res_r[ROOT_W-1:0], lim: lim_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_push) begin
            t_r     <= t_sat;
            lim_r   <= (deg_lim > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : deg_lim;
            rem_r   <= {1'b0, rad, 18'd0};
            res_r   <= '0;
            bit_r   <= 48'd1 << 46;
            state_r <= F_SQRT;
          end
        end
        F_SQRT: begin
          if (rem_r >= trial) begin
            rem_r <= rem_r - trial;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r == 48'd1) state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (!tsk_full) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/nlr_task_q.sv
// two-entry queue of prepared samples between front and back
module nlr_task_q (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  nlr_pkg::task_t din,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output nlr_pkg::task_t dout
);
  import nlr_pkg::*;

  task_t      mem_r [2];
  logic       wptr_r;
  logic       rptr_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wptr_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push && !full) wptr_r <= !wptr_r;
      if (pop && !empty) rptr_r <= !rptr_r;
      cnt_r <= cnt_r + 2'(push && !full) - 2'(pop && !empty);
    end
  end

endmodule

FILE: hw/rtl/nlr_back.sv
// back end: recursion sequencer on one shared multiplier, with result queue
module nlr_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  nlr_pkg::task_t                  tsk,
  input  logic                            tsk_empty,
  output logic                            tsk_pop,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic signed [nlr_pkg::VAL_W-1:0] out_value,
  output logic [nlr_pkg::DEG_W-1:0]       out_degree,
  output logic [nlr_pkg::DEG_W-1:0]       out_order,
  output logic                            out_last
);
  import nlr_pkg::*;
  `include "normalized_legendre_recursion_core_assert.svh"

  typedef enum logic [2:0] {B_IDLE, B_COEF, B_AT, B_P1, B_P2, B_WR} bstate_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [DEG_W-1:0]        degree;
    logic [DEG_W-1:0]        order;
    logic                    last;
  } res_t;

  function automatic logic signed [57:0] rnd_shr(input logic signed [57:0] x, input int sh);
    logic [57:0] m;
    m = x[57] ? 58'(-x) : 58'(x);
    m = (m + (58'd1 << (sh - 1))) >> sh;
    return x[57] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [VAL_W-1:0] sat24(input logic signed [57:0] x);
    if (x > 58'sd8388607) return 24'sh7FFFFF;
    if (x < -58'sd8388608) return 24'sh800000;
    return x[VAL_W-1:0];
  endfunction

  bstate_t                 state_r;
  logic signed [T_W-1:0]   t_r;
  logic [ROOT_W-1:0]       s_r;
  logic [DEG_W-1:0]        lim_r;
  logic [DEG_W-1:0]        k_r;
  logic [DEG_W-1:0]        l_r;
  logic signed [31:0]      at_r;
  logic signed [56:0]      prod_r;
  logic signed [56:0]      acc_r;
  logic signed [VAL_W-1:0] row1_r [MAX_DEGREE+1];
  logic signed [VAL_W-1:0] row2_r [MAX_DEGREE+1];
  logic signed [VAL_W-1:0] rnew_r [MAX_DEGREE+1];

  res_t       oq_r [2];
  logic       owp_r;
  logic       orp_r;
  logic [1:0] ocnt_r;

  logic [7:0]              tri_k;
  logic [IDX_W-1:0]        cidx;
  logic                    gen;
  logic                    diag;
  logic signed [31:0]      mul_a;
  logic signed [24:0]      mul_b;
  logic signed [56:0]      mul_p;
  logic signed [VAL_W-1:0] r1;
  logic signed [57:0]      diff;
  logic signed [VAL_W-1:0] val;
  logic                    wr;
  logic                    opop;
  logic                    at_end;

  always_comb begin
    tri_k = (8'(k_r) * 8'(k_r + 4'd1)) >> 1;
    cidx  = IDX_W'(tri_k + 8'(l_r));
    gen   = (5'(l_r) + 5'd1) < 5'(k_r);
    diag  = (l_r == k_r);
    r1    = gen ? row1_r[l_r] : row1_r[k_r - 4'd1];
    case (state_r)
      B_COEF: begin
        mul_a = 32'(COEF_A[cidx]);
        mul_b = diag ? $signed({1'b0, s_r}) : 25'(t_r);
      end
      B_P1: begin
        mul_a = at_r;
        mul_b = 25'(r1);
      end
      default: begin
        mul_a = 32'(COEF_B[cidx]);
        mul_b = 25'(row2_r[l_r]);
      end
    endcase
    mul_p  = mul_a * mul_b;
    diff   = 58'(acc_r) - (gen ? 58'(prod_r) : 58'sd0);
    val    = (k_r == '0) ? SEED_VAL : sat24(rnd_shr(diff, 26));
    wr     = (state_r == B_WR) && (ocnt_r != 2'd2);
    opop   = out_pop && (ocnt_r != 2'd0);
    at_end = diag && (k_r == lim_r);
  end

  assign tsk_pop    = (state_r == B_IDLE) && !tsk_empty;
  assign out_empty  = (ocnt_r == 2'd0);
  assign out_value  = oq_r[orp_r].value;
  assign out_degree = oq_r[orp_r].degree;
  assign out_order  = oq_r[orp_r].order;
  assign out_last   = oq_r[orp_r].last;

  // datapath and row storage
  always_ff @(posedge clk) begin
    if (state_r == B_COEF || state_r == B_P1 || state_r == B_P2) prod_r <= mul_p;
    if (state_r == B_P2) acc_r <= prod_r;
    if (state_r == B_AT) begin
      at_r <= diag ? 32'(rnd_shr(58'(prod_r), 23)) : 32'(rnd_shr(58'(prod_r), 14));
    end
    if (wr) begin
      oq_r[owp_r] <= '{value: val, degree: k_r, order: l_r, last: at_end};
      rnew_r[l_r] <= val;
      if (diag) begin
        for (int i = 0; i <= MAX_DEGREE; i++) begin
          row2_r[i] <= row1_r[i];
          if (i == int'(k_r)) row1_r[i] <= val;
          else if (i < int'(k_r)) row1_r[i] <= rnew_r[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      owp_r   <= 1'b0;
      orp_r   <= 1'b0;
      ocnt_r  <= 2'd0;
      k_r     <= '0;
      l_r     <= '0;
    end else begin
      if (wr) owp_r <= !owp_r;
      if (opop) orp_r <= !orp_r;
      ocnt_r <= ocnt_r + 2'(wr) - 2'(opop);
      case (state_r)
        B_IDLE: begin
          if (!tsk_empty) begin
            t_r     <= tsk.t;
            s_r     <= tsk.root;
            lim_r   <= tsk.lim;
            k_r     <= '0;
            l_r     <= '0;
            state_r <= B_WR;
          end
        end
        B_COEF: state_r <= B_AT;
        B_AT:   state_r <= B_P1;
        B_P1:   state_r <= B_P2;
        B_P2:   state_r <= B_WR;
        B_WR: begin
          if (wr) begin
            if (at_end) begin
              state_r <= B_IDLE;
            end else if (diag) begin
              k_r     <= k_r + 4'd1;
              l_r     <= '0;
              state_r <= B_COEF;
            end else begin
              l_r     <= l_r + 4'd1;
              state_r <= B_COEF;
            end
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  `NLR_ASSERT_NOW(a_order_le_degree, !out_empty, out_order <= out_degree)
  `NLR_ASSERT_NOW(a_last_on_diag, !out_empty && out_last, out_order == out_degree)
  `NLR_ASSERT_NOW(a_degree_in_limit, state_r != B_IDLE, k_r <= lim_r && l_r <= k_r)
  `NLR_ASSERT_NEXT(a_last_goes_idle, wr && at_end, state_r == B_IDLE)

endmodule
